### rtl/qrau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrau_pkg
// Shared types and constants of the qubit rotation angle update core.
// ----------------------------------------------------------------------------
package qrau_pkg;

    // Width of the rotation step registers
    localparam int ROT_BITS  = 30;
    // Configuration port
    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;

    localparam logic [ROT_BITS-1:0] ROT_LOW_RESET  = 30'd1073742;
    localparam logic [ROT_BITS-1:0] ROT_HIGH_RESET = 30'd53687091;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_ROT_LOW   = 2'd0;
    localparam logic [1:0] REG_ROT_HIGH  = 2'd1;
    localparam logic [1:0] REG_DIR_TABLE = 2'd2;

    // Direction table entry codes
    localparam logic [1:0] CODE_NONE   = 2'd0;
    localparam logic [1:0] CODE_PLUS   = 2'd1;
    localparam logic [1:0] CODE_MINUS  = 2'd2;
    localparam logic [1:0] CODE_RANDOM = 2'd3;

    // Signed direction as carried through the pipeline and on the output
    localparam logic signed [1:0] DIR_ZERO = 2'sb00;
    localparam logic signed [1:0] DIR_POS  = 2'sb01;
    localparam logic signed [1:0] DIR_NEG  = 2'sb11;

    // Angle columns of theta/2
    localparam logic [1:0] COL_SAME_SIGN = 2'd0;
    localparam logic [1:0] COL_OPP_SIGN  = 2'd1;
    localparam logic [1:0] COL_COS_ZERO  = 2'd2;
    localparam logic [1:0] COL_SIN_ZERO  = 2'd3;

    // Queue between front and back
    localparam int QDEPTH    = 2;
    localparam int QPTR_BITS = 1;
    localparam int QCNT_BITS = 2;

    typedef struct packed {
        logic [ROT_BITS-1:0] rot_low;
        logic [ROT_BITS-1:0] rot_high;
        logic [31:0]         dir_table;
    } qrau_cfg_t;

endpackage

### rtl/qrau_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrau_front
// Classifies an incoming item: picks the direction and forms gap and maximum.
// ----------------------------------------------------------------------------
module qrau_front #(
    parameter int ANGLE_BITS   = 32,
    parameter int FITNESS_BITS = 32
) (
    input  qrau_pkg::qrau_cfg_t       cfg,
    input  logic [ANGLE_BITS-1:0]     theta_in,
    input  logic                      current_bit,
    input  logic                      best_bit,
    input  logic [FITNESS_BITS-1:0]   fitness_current,
    input  logic [FITNESS_BITS-1:0]   fitness_best,
    input  logic                      random_choice,
    output logic signed [1:0]         dir,
    output logic [FITNESS_BITS-1:0]   gap,
    output logic [FITNESS_BITS-1:0]   max_fit
);
    import qrau_pkg::*;

    logic                    cur_gt;
    logic [FITNESS_BITS-1:0] mx;
    logic                    on_axis;
    logic [1:0]              col;
    logic [3:0]              idx;
    logic [1:0]              code;

    assign cur_gt = fitness_current > fitness_best;
    assign gap    = cur_gt ? (fitness_current - fitness_best)
                           : (fitness_best - fitness_current);
    assign mx     = cur_gt ? fitness_current : fitness_best;
    // A zero maximum divides by one: gap is zero too, so the step stays low
    assign max_fit = (mx == '0) ? {{(FITNESS_BITS-1){1'b0}}, 1'b1} : mx;

    assign on_axis = (theta_in[ANGLE_BITS-3:0] == '0);

    always_comb
    begin
        case ({on_axis, theta_in[ANGLE_BITS-2]})
            2'b00:   col = COL_SAME_SIGN;
            2'b01:   col = COL_OPP_SIGN;
            2'b11:   col = COL_COS_ZERO;
            default: col = COL_SIN_ZERO;
        endcase
    end

    // Index wraps at 16
    assign idx  = {current_bit, best_bit, cur_gt, 1'b0} + {2'b00, col};
    assign code = cfg.dir_table[{idx, 1'b0} +: 2];

    always_comb
    begin
        case (code)
            CODE_PLUS:   dir = DIR_POS;
            CODE_MINUS:  dir = DIR_NEG;
            CODE_RANDOM: dir = random_choice ? DIR_NEG : DIR_POS;
            default:     dir = DIR_ZERO;
        endcase
    end

endmodule

### rtl/qrau_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrau_queue
// Small register queue between the front and the back.
// ----------------------------------------------------------------------------
module qrau_queue #(
    parameter int WIDTH = 98
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    import qrau_pkg::*;

    logic [WIDTH-1:0]     data_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic                 push, pop;

    assign in_ready  = (count_reg != QCNT_BITS'(QDEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = data_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

### rtl/qrau_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrau_back
// Pipelined scaled divide, step formation and angle update with output register.
// ----------------------------------------------------------------------------
module qrau_back #(
    parameter int ANGLE_BITS   = 32,
    parameter int FITNESS_BITS = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  qrau_pkg::qrau_cfg_t      cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [ANGLE_BITS-1:0]    in_theta,
    input  logic signed [1:0]        in_dir,
    input  logic [FITNESS_BITS-1:0]  in_gap,
    input  logic [FITNESS_BITS-1:0]  in_max,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [ANGLE_BITS-1:0]    theta_out,
    output logic signed [1:0]        direction
);
    import qrau_pkg::*;

    localparam int S  = ROT_BITS;
    localparam int F  = FITNESS_BITS;
    localparam int DW = ROT_BITS + 1;

    logic                adv;
    logic                hi_ge;
    logic [ROT_BITS-1:0] span;

    // Divider stages: one bit of the span per stage
    logic                  vld_reg   [S];
    logic [ANGLE_BITS-1:0] theta_reg [S];
    logic signed [1:0]     dir_reg   [S];
    logic [F-1:0]          d_reg     [S];
    logic [F-1:0]          m_reg     [S];
    logic [F-1:0]          rem_reg   [S];
    logic [ROT_BITS-1:0]   q_reg     [S];

    logic                  vld_next   [S];
    logic [ANGLE_BITS-1:0] theta_next [S];
    logic signed [1:0]     dir_next   [S];
    logic [F-1:0]          d_next     [S];
    logic [F-1:0]          m_next     [S];
    logic [F-1:0]          rem_next   [S];
    logic [ROT_BITS-1:0]   q_next     [S];

    // Step stage
    logic                  step_vld_reg;
    logic [ROT_BITS-1:0]   step_reg, step_next;
    logic [ANGLE_BITS-1:0] step_theta_reg;
    logic signed [1:0]     step_dir_reg;

    // Output register
    logic                  out_valid_reg;
    logic [ANGLE_BITS-1:0] theta_out_reg, theta_out_next;
    logic signed [1:0]     direction_reg;

    logic [ANGLE_BITS+DW-1:0] delta_wide;
    logic [ANGLE_BITS-1:0]    delta;
    logic                     inexact;

    // The whole back end moves together unless the output is stalled
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    assign hi_ge = cfg.rot_high >= cfg.rot_low;
    assign span  = hi_ge ? (cfg.rot_high - cfg.rot_low) : (cfg.rot_low - cfg.rot_high);

    always_comb
    begin
        logic                  s_vld;
        logic [ANGLE_BITS-1:0] s_theta;
        logic signed [1:0]     s_dir;
        logic [F-1:0]          s_d;
        logic [F-1:0]          s_m;
        logic [F-1:0]          s_rem;
        logic [ROT_BITS-1:0]   s_q;
        logic [F+1:0]          t;
        logic [F+1:0]          m1;
        logic [F+1:0]          m2;
        logic [1:0]            k;
        for (int i = 0; i < S; i++)
        begin
            if (i == 0)
            begin
                s_vld   = in_valid;
                s_theta = in_theta;
                s_dir   = in_dir;
                s_d     = in_gap;
                s_m     = in_max;
                s_rem   = '0;
                s_q     = '0;
            end
            else
            begin
                s_vld   = vld_reg[i-1];
                s_theta = theta_reg[i-1];
                s_dir   = dir_reg[i-1];
                s_d     = d_reg[i-1];
                s_m     = m_reg[i-1];
                s_rem   = rem_reg[i-1];
                s_q     = q_reg[i-1];
            end
            // rem < m and d <= m, so t < 3m
            t  = {1'b0, s_rem, 1'b0} + (span[S-1-i] ? {2'b00, s_d} : '0);
            m1 = {2'b00, s_m};
            m2 = {1'b0, s_m, 1'b0};
            if (t >= m2)
            begin
                k = 2'd2;
                t = t - m2;
            end
            else if (t >= m1)
            begin
                k = 2'd1;
                t = t - m1;
            end
            else
            begin
                k = 2'd0;
            end
            vld_next[i]   = s_vld;
            theta_next[i] = s_theta;
            dir_next[i]   = s_dir;
            d_next[i]     = s_d;
            m_next[i]     = s_m;
            rem_next[i]   = t[F-1:0];
            q_next[i]     = {s_q[ROT_BITS-2:0], 1'b0} + {{(ROT_BITS-2){1'b0}}, k};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < S; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            step_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            for (int i = 0; i < S; i++)
            begin
                vld_reg[i] <= vld_next[i];
            end
            step_vld_reg  <= vld_reg[S-1];
            out_valid_reg <= step_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < S; i++)
            begin
                theta_reg[i] <= theta_next[i];
                dir_reg[i]   <= dir_next[i];
                d_reg[i]     <= d_next[i];
                m_reg[i]     <= m_next[i];
                rem_reg[i]   <= rem_next[i];
                q_reg[i]     <= q_next[i];
            end
            step_reg       <= step_next;
            step_theta_reg <= theta_reg[S-1];
            step_dir_reg   <= dir_reg[S-1];
            theta_out_reg  <= theta_out_next;
            direction_reg  <= step_dir_reg;
        end
    end

    // Descending step rounds the subtracted part up, i.e. truncates toward zero
    assign inexact   = (rem_reg[S-1] != '0);
    assign step_next = hi_ge ? (cfg.rot_low + q_reg[S-1])
                             : (cfg.rot_low - q_reg[S-1] - {{(ROT_BITS-1){1'b0}}, inexact});

    assign delta_wide = {{ANGLE_BITS{1'b0}}, step_reg, 1'b0};
    assign delta      = delta_wide[ANGLE_BITS-1:0];

    always_comb
    begin
        case (step_dir_reg)
            DIR_POS: theta_out_next = step_theta_reg + delta;
            DIR_NEG: theta_out_next = step_theta_reg - delta;
            default: theta_out_next = step_theta_reg;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign theta_out = theta_out_reg;
    assign direction = direction_reg;

endmodule

### rtl/qubit_rotation_angle_update_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qubit_rotation_angle_update_core
// Rotation gate update of one qubit angle per transaction: direction from a
// configurable table, step interpolated by the relative fitness gap.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_ready  | theta_in, current_bit, best_bit,
//           |                      | fitness_current, fitness_best, random_choice
//  output   | out_valid / out_ready| theta_out, direction
//  config   | APB psel/penable     | paddr, pwdata, prdata (pready tied high)
//
//  One transaction per cycle, sustained while the output is not stalled. From
//  input accept to out_valid a transaction passes the queue, the divider
//  pipeline, the step stage and the output register; an empty queue
//  hands the transaction on in the cycle after the accept.
//  Reset clears all valid flags and loads the register defaults; no
//  clearing pass. An output stall freezes the back pipeline, and the
//  two-entry queue keeps in_ready high until it fills.
//
module qubit_rotation_angle_update_core #(
    parameter int ANGLE_BITS   = 32,
    parameter int FITNESS_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // config port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [qrau_pkg::ADDR_BITS-1:0]    paddr,
    input  logic [qrau_pkg::DATA_BITS-1:0]    pwdata,
    output logic [qrau_pkg::DATA_BITS-1:0]    prdata,
    output logic                              pready,
    // input channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ANGLE_BITS-1:0]             theta_in,
    input  logic                              current_bit,
    input  logic                              best_bit,
    input  logic [FITNESS_BITS-1:0]           fitness_current,
    input  logic [FITNESS_BITS-1:0]           fitness_best,
    input  logic                              random_choice,
    // output channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ANGLE_BITS-1:0]             theta_out,
    output logic signed [1:0]                 direction
);
    import qrau_pkg::*;

    localparam int QW = ANGLE_BITS + 2 + 2 * FITNESS_BITS;

    // Configuration registers
    logic [ROT_BITS-1:0] rot_low_reg, rot_low_next;
    logic [ROT_BITS-1:0] rot_high_reg, rot_high_next;
    logic [31:0]         dir_table_reg, dir_table_next;
    logic                cfg_write;
    qrau_cfg_t           cfg;

    // Front to queue
    logic signed [1:0]        f_dir;
    logic [FITNESS_BITS-1:0]  f_gap;
    logic [FITNESS_BITS-1:0]  f_max;
    logic [QW-1:0]            q_in_data;

    // Queue to back
    logic                     q_out_valid;
    logic                     q_out_ready;
    logic [QW-1:0]            q_out_data;
    logic [ANGLE_BITS-1:0]    b_theta;
    logic signed [1:0]        b_dir;
    logic [FITNESS_BITS-1:0]  b_gap;
    logic [FITNESS_BITS-1:0]  b_max;

    // ------------------------------------------------------------------
    // Config port: zero-wait APB, write on the access phase
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        rot_low_next   = rot_low_reg;
        rot_high_next  = rot_high_reg;
        dir_table_next = dir_table_reg;
        if (cfg_write)
        begin
            case (paddr[ADDR_BITS-1:2])
                REG_ROT_LOW:   rot_low_next   = pwdata[ROT_BITS-1:0];
                REG_ROT_HIGH:  rot_high_next  = pwdata[ROT_BITS-1:0];
                REG_DIR_TABLE: dir_table_next = pwdata;
                default:       ;  // drop writes outside the register map
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_low_reg   <= ROT_LOW_RESET;
            rot_high_reg  <= ROT_HIGH_RESET;
            dir_table_reg <= '0;
        end
        else
        begin
            rot_low_reg   <= rot_low_next;
            rot_high_reg  <= rot_high_next;
            dir_table_reg <= dir_table_next;
        end
    end

    always_comb
    begin
        case (paddr[ADDR_BITS-1:2])
            REG_ROT_LOW:   prdata = {{(DATA_BITS-ROT_BITS){1'b0}}, rot_low_reg};
            REG_ROT_HIGH:  prdata = {{(DATA_BITS-ROT_BITS){1'b0}}, rot_high_reg};
            REG_DIR_TABLE: prdata = dir_table_reg;
            default:       prdata = '0;
        endcase
    end

    assign cfg.rot_low   = rot_low_reg;
    assign cfg.rot_high  = rot_high_reg;
    assign cfg.dir_table = dir_table_reg;

    // ------------------------------------------------------------------
    // Front: classify the transaction into direction, gap and maximum
    // ------------------------------------------------------------------
    qrau_front #(
        .ANGLE_BITS   (ANGLE_BITS),
        .FITNESS_BITS (FITNESS_BITS)
    ) u_front (
        .cfg             (cfg),
        .theta_in        (theta_in),
        .current_bit     (current_bit),
        .best_bit        (best_bit),
        .fitness_current (fitness_current),
        .fitness_best    (fitness_best),
        .random_choice   (random_choice),
        .dir             (f_dir),
        .gap             (f_gap),
        .max_fit         (f_max)
    );

    assign q_in_data = {theta_in, f_dir, f_gap, f_max};

    // ------------------------------------------------------------------
    // Queue: decouple the input handshake from the back pipeline
    // ------------------------------------------------------------------
    qrau_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (q_in_data),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_data  (q_out_data)
    );

    assign {b_theta, b_dir, b_gap, b_max} = q_out_data;

    // ------------------------------------------------------------------
    // Back: divide, form the step, rotate the angle
    // ------------------------------------------------------------------
    qrau_back #(
        .ANGLE_BITS   (ANGLE_BITS),
        .FITNESS_BITS (FITNESS_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (q_out_valid),
        .in_ready  (q_out_ready),
        .in_theta  (b_theta),
        .in_dir    (b_dir),
        .in_gap    (b_gap),
        .in_max    (b_max),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .theta_out (theta_out),
        .direction (direction)
    );

endmodule

### rtl/qrau_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrau_checker
// Port-level checks of the rotation angle update core, bound to the top level.
// ----------------------------------------------------------------------------
module qrau_checker #(
    parameter int ANGLE_BITS   = 32,
    parameter int FITNESS_BITS = 32
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   pready,
    input logic                   in_valid,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [ANGLE_BITS-1:0]  theta_out,
    input logic signed [1:0]      direction,
    input logic [FITNESS_BITS-1:0] fitness_current
);
    import qrau_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(theta_out) && $stable(direction))
        else $error("output transaction changed while stalled");

    // Drop every result once reset has been seen at an edge
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid after reset");

    // Only the three legal directions leave the block
    a_dir_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (direction == DIR_ZERO || direction == DIR_POS || direction == DIR_NEG))
        else $error("illegal direction code");

    // Config port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid || !in_valid || fitness_current == fitness_current |-> pready)
        else $error("pready low");

endmodule

bind qubit_rotation_angle_update_core qrau_checker #(
    .ANGLE_BITS   (ANGLE_BITS),
    .FITNESS_BITS (FITNESS_BITS)
) u_qrau_checker (.*);

### sim/tb_qubit_rotation_angle_update_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_qubit_rotation_angle_update_core
// Self-checking bench for the rotation angle update core. An initial block
// programs the registers over APB and fills a queue of angle transactions;
// a clocked driver feeds them to the input channel and predicts each update
// at acceptance; a clocked monitor compares every output transaction, field
// by field, with the oldest prediction. Random idling on both channels and
// one long output stall exercise the back-pressure path.
// ----------------------------------------------------------------------------
module tb_qubit_rotation_angle_update_core;

    import qrau_pkg::*;

    localparam int ANGLE_W       = 32;
    localparam int FIT_W         = 32;
    // Let the pipeline empty before the final verdict
    localparam int SETTLE_CYCLES = 48;
    // Long output stall, long enough to back the pipeline up into in_ready
    localparam int HOLD_CYCLES   = 200;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 225;

    localparam logic [ROT_BITS-1:0] ROT_MAX = {ROT_BITS{1'b1}};

    // One input transaction
    typedef struct {
        logic [ANGLE_W-1:0] theta;
        logic               cur_bit;
        logic               best_bit;
        logic [FIT_W-1:0]   fit_cur;
        logic [FIT_W-1:0]   fit_best;
        logic               rnd;
    } rot_item_t;

    // One output transaction
    typedef struct {
        logic [ANGLE_W-1:0] theta;
        logic signed [1:0]  dir;
    } rot_update_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [ADDR_BITS-1:0]  paddr   = '0;
    logic [DATA_BITS-1:0]  pwdata  = '0;
    logic [DATA_BITS-1:0]  prdata;
    logic                  pready;

    logic                  in_valid        = 1'b0;
    logic                  in_ready;
    logic [ANGLE_W-1:0]    theta_in        = '0;
    logic                  current_bit     = 1'b0;
    logic                  best_bit        = 1'b0;
    logic [FIT_W-1:0]      fitness_current = '0;
    logic [FIT_W-1:0]      fitness_best    = '0;
    logic                  random_choice   = 1'b0;

    logic                  out_valid;
    logic                  out_ready       = 1'b0;
    logic [ANGLE_W-1:0]    theta_out;
    logic signed [1:0]     direction;

    // Bench copy of the register file, used by the predictor
    qrau_cfg_t     cfg_model;

    rot_item_t     pending_items[$];
    rot_update_t   expected_updates[$];
    rot_item_t     offered_item;

    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    bit            hold_request  = 1'b0;
    int            hold_left     = 0;
    int unsigned   accepted_total = 0;
    int unsigned   fail_count     = 0;
    int unsigned   cycle_count    = 0;

    qubit_rotation_angle_update_core #(
        .ANGLE_BITS   (ANGLE_W),
        .FITNESS_BITS (FIT_W)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .theta_in        (theta_in),
        .current_bit     (current_bit),
        .best_bit        (best_bit),
        .fitness_current (fitness_current),
        .fitness_best    (fitness_best),
        .random_choice   (random_choice),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .theta_out       (theta_out),
        .direction       (direction)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: direction from the table, step interpolated by the
    // relative fitness gap, angle moved by twice the step.
    // ------------------------------------------------------------------
    function automatic rot_update_t predict_rotation(input rot_item_t it);
        logic              cmp;
        logic [1:0]        col;
        logic [3:0]        idx;
        logic [1:0]        code;
        logic [63:0]       lo;
        logic [63:0]       hi;
        logic [63:0]       fmax;
        logic [63:0]       gap;
        logic [63:0]       step;
        logic [ANGLE_W-1:0] delta;
        rot_update_t       upd;
        cmp = (it.fit_cur > it.fit_best);
        // Column of theta/2: quadrant is the top two bits, an axis when
        // the rest is zero
        if (it.theta[ANGLE_W-3:0] == '0)
            col = it.theta[ANGLE_W-2] ? COL_COS_ZERO : COL_SIN_ZERO;
        else
            col = it.theta[ANGLE_W-2] ? COL_OPP_SIGN : COL_SAME_SIGN;
        // Four-bit sum: indexes 16 and 17 fold back onto entries 0 and 1
        idx  = {it.cur_bit, it.best_bit, cmp, 1'b0} + {2'b00, col};
        code = cfg_model.dir_table[2*idx +: 2];
        case (code)
            CODE_PLUS:   upd.dir = DIR_POS;
            CODE_MINUS:  upd.dir = DIR_NEG;
            CODE_RANDOM: upd.dir = it.rnd ? DIR_NEG : DIR_POS;
            default:     upd.dir = DIR_ZERO;
        endcase
        lo   = 64'(cfg_model.rot_low);
        hi   = 64'(cfg_model.rot_high);
        fmax = cmp ? 64'(it.fit_cur) : 64'(it.fit_best);
        gap  = cmp ? 64'(it.fit_cur - it.fit_best) : 64'(it.fit_best - it.fit_cur);
        if (fmax == 0)
            step = lo;
        else if (hi >= lo)
            step = lo + ((hi - lo) * gap) / fmax;
        else
            // Interpolated value truncated toward zero: round the drop up
            step = lo - (((lo - hi) * gap + fmax - 1) / fmax);
        delta = ANGLE_W'(step << 1);
        if (upd.dir == DIR_POS)
            upd.theta = it.theta + delta;
        else if (upd.dir == DIR_NEG)
            upd.theta = it.theta - delta;
        else
            upd.theta = it.theta;
        return upd;
    endfunction

    function automatic rot_item_t make_item(input logic [ANGLE_W-1:0] theta,
                                            input logic cb, input logic bb,
                                            input logic [FIT_W-1:0] fc,
                                            input logic [FIT_W-1:0] fb,
                                            input logic rnd);
        rot_item_t it;
        it.theta    = theta;
        it.cur_bit  = cb;
        it.best_bit = bb;
        it.fit_cur  = fc;
        it.fit_best = fb;
        it.rnd      = rnd;
        return it;
    endfunction

    // Random transaction biased toward axis angles and fitness corner cases
    function automatic rot_item_t random_rotation_item();
        rot_item_t   it;
        logic [1:0]  quad;
        logic [31:0] base;
        quad = 2'($urandom_range(3));
        base = $urandom;
        case ($urandom_range(7))
            0:       it.theta = {quad, {(ANGLE_W-2){1'b0}}};
            1:       it.theta = {quad, {(ANGLE_W-2){1'b1}}};
            2:       it.theta = {quad, {(ANGLE_W-3){1'b0}}, 1'b1};
            default: it.theta = $urandom;
        endcase
        it.cur_bit  = 1'($urandom_range(1));
        it.best_bit = 1'($urandom_range(1));
        it.rnd      = 1'($urandom_range(1));
        case ($urandom_range(7))
            0: begin it.fit_cur = '0;   it.fit_best = '0;   end
            1: begin it.fit_cur = base; it.fit_best = base; end
            2: begin it.fit_cur = '0;   it.fit_best = base; end
            3: begin it.fit_cur = base; it.fit_best = '0;   end
            4:
            begin
                it.fit_cur  = $urandom_range(20);
                it.fit_best = $urandom_range(20);
            end
            5: begin it.fit_cur = '1;   it.fit_best = base; end
            default:
            begin
                it.fit_cur  = $urandom;
                it.fit_best = $urandom;
            end
        endcase
        return it;
    endfunction

    // ------------------------------------------------------------------
    // APB write: setup cycle, access cycle, register lands on the edge
    // that ends the access cycle (pready is tied high).
    // ------------------------------------------------------------------
    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_config(input logic [ROT_BITS-1:0] lo, input logic [ROT_BITS-1:0] hi,
                                input logic [31:0] tbl);
        write_register(REG_ROT_LOW, 32'(lo));
        write_register(REG_ROT_HIGH, 32'(hi));
        write_register(REG_DIR_TABLE, tbl);
        cfg_model.rot_low   = lo;
        cfg_model.rot_high  = hi;
        cfg_model.dir_table = tbl;
    endtask

    // Hold until every queued transaction is accepted and every update seen;
    // sample at the falling edge so the driver's updates have settled
    task automatic drain();
        while (pending_items.size() != 0 || in_valid || expected_updates.size() != 0)
            @(negedge clk);
    endtask

    task automatic random_phase(input int snd_pct, input int rcv_pct,
                                input logic [ROT_BITS-1:0] lo,
                                input logic [ROT_BITS-1:0] hi,
                                input logic [31:0] tbl, input bit with_hold);
        int unsigned start;
        apply_config(lo, hi, tbl);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        start = accepted_total;
        repeat (PHASE_ITEMS) pending_items.push_back(random_rotation_item());
        if (with_hold)
        begin
            // Let traffic flow first, then freeze the receiver while the
            // sender keeps offering
            while (accepted_total < start + 20)
                @(posedge clk);
            @(negedge clk);
            hold_request = 1'b1;
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // Input driver: present queued transactions with random gaps, predict
    // each one at the edge where it is accepted.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_updates.push_back(predict_rotation(offered_item));
                accepted_total++;
            end
            // Advance only when nothing is on offer or the offer just went
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered_item    = pending_items.pop_front();
                    in_valid        <= 1'b1;
                    theta_in        <= offered_item.theta;
                    current_bit     <= offered_item.cur_bit;
                    best_bit        <= offered_item.best_bit;
                    fitness_current <= offered_item.fit_cur;
                    fitness_best    <= offered_item.fit_best;
                    random_choice   <= offered_item.rnd;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: check each accepted transaction against the oldest
    // prediction, then pick the next ready value (random or held off).
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_updates.size() == 0)
                begin
                    $error("update with no prediction waiting: theta_out %h direction %0d",
                           theta_out, direction);
                    fail_count++;
                end
                else
                begin
                    rot_update_t exp_upd;
                    exp_upd = expected_updates.pop_front();
                    if (theta_out !== exp_upd.theta)
                    begin
                        $error("theta_out mismatch: expected %h, actual %h",
                               exp_upd.theta, theta_out);
                        fail_count++;
                    end
                    if (direction !== exp_upd.dir)
                    begin
                        $error("direction mismatch: expected %0d, actual %0d",
                               exp_upd.dir, direction);
                        fail_count++;
                    end
                end
            end
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Drop the run if it hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial
    begin
        cfg_model.rot_low   = ROT_LOW_RESET;
        cfg_model.rot_high  = ROT_HIGH_RESET;
        cfg_model.dir_table = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults: an all-zero table leaves every angle untouched
        pending_items.push_back(make_item(32'h1234_5678, 1'b1, 1'b0, 32'd100, 32'd50, 1'b0));
        pending_items.push_back(make_item(32'hFFFF_FFFF, 1'b1, 1'b1, '1, '0, 1'b1));
        drain();

        // Entry code follows the column while the current fitness is not above the best:
        // same sign none, opposite sign plus, cos zero minus, sin zero random sign
        apply_config('0, ROT_MAX, 32'hE4E4_E4E4);
        // Both fitnesses zero on each axis: step is the low bound
        pending_items.push_back(make_item(32'h0000_0000, 1'b0, 1'b0, '0, '0, 1'b0));
        pending_items.push_back(make_item(32'h4000_0000, 1'b0, 1'b0, '0, '0, 1'b1));
        pending_items.push_back(make_item(32'h8000_0000, 1'b0, 1'b1, '0, '0, 1'b1));
        // Full gap: step is the high bound; then a partial gap off the axis
        pending_items.push_back(make_item(32'hC000_0000, 1'b0, 1'b0, '1, '0, 1'b0));
        pending_items.push_back(make_item(32'h0000_0001, 1'b1, 1'b0, 32'd7, 32'd9, 1'b0));
        // Plus across the top of the word: the angle wraps
        pending_items.push_back(make_item(32'hFFFF_FFFF, 1'b0, 1'b0, '0, '1, 1'b0));
        // Index past the table end folds onto entries 0 and 1
        pending_items.push_back(make_item(32'h4000_0000, 1'b1, 1'b1, 32'd10, 32'd5, 1'b0));
        pending_items.push_back(make_item(32'h0000_0000, 1'b1, 1'b1, 32'd10, 32'd5, 1'b1));
        // Equal nonzero fitness: no gap, low bound; then a wide gap
        pending_items.push_back(make_item(32'h9ABC_DEF0, 1'b0, 1'b1, 32'd77, 32'd77, 1'b0));
        pending_items.push_back(make_item(32'h6000_0001, 1'b1, 1'b0, 32'd3, 32'd1000, 1'b1));
        drain();

        // High below low, every entry random sign
        apply_config(ROT_MAX, '0, 32'hFFFF_FFFF);
        pending_items.push_back(make_item(32'h2468_ACE0, 1'b0, 1'b0, 32'd3, 32'd2, 1'b0));
        pending_items.push_back(make_item(32'hDB97_531F, 1'b1, 1'b0, '0, '0, 1'b1));
        pending_items.push_back(make_item(32'h1357_9BDF, 1'b0, 1'b1, 32'd7, 32'd7, 1'b0));
        pending_items.push_back(make_item(32'hA5A5_5A5A, 1'b1, 1'b1, '1, 32'd1, 1'b1));
        drain();

        // Equal bounds, all plus, then all minus below zero
        apply_config(30'd12345, 30'd12345, 32'h5555_5555);
        pending_items.push_back(make_item(32'hFFFF_FFFF, 1'b1, 1'b0, 32'd9, 32'd4, 1'b0));
        drain();
        apply_config(30'd12345, 30'd12345, 32'hAAAA_AAAA);
        pending_items.push_back(make_item(32'h0000_0000, 1'b0, 1'b1, 32'd4, 32'd9, 1'b1));
        drain();

        // Random traffic: sender dense / receiver busy, the reverse, full rate with
        // one long output stall, then equal bounds, a small low bound and the reset bounds
        random_phase(11, 83, '0, ROT_MAX, $urandom, 1'b0);
        random_phase(83, 11, ROT_MAX, '0, $urandom, 1'b0);
        random_phase(0, 0, ROT_BITS'($urandom), ROT_BITS'($urandom), $urandom, 1'b1);
        begin
            logic [ROT_BITS-1:0] same_bound;
            same_bound = ROT_BITS'($urandom);
            random_phase(11, 83, same_bound, same_bound, $urandom, 1'b0);
        end
        random_phase(83, 11, ROT_BITS'($urandom_range(1000)), ROT_BITS'($urandom),
                     $urandom, 1'b0);
        random_phase(0, 0, ROT_LOW_RESET, ROT_HIGH_RESET, $urandom, 1'b0);

        // Catch any stray update after the last prediction was matched
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_updates.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
rtl/qrau_pkg.sv
rtl/qrau_front.sv
rtl/qrau_queue.sv
rtl/qrau_back.sv
rtl/qubit_rotation_angle_update_core.sv
rtl/qrau_checker.sv
sim/tb_qubit_rotation_angle_update_core.sv
